// ===== design/mbrtu_pkg.sv =====
`timescale 1ns / 1ps

package mbrtu_pkg;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [8:0] FRAME_LEN_BASE  = 9'd8;
  localparam logic [8:0] FRAME_LEN_MULTI = 9'd9;

  localparam logic [7:0] FC_LOW_MAX     = 8'd6;
  localparam logic [7:0] FC_WRITE_COILS = 8'd15;
  localparam logic [7:0] FC_WRITE_REGS  = 8'd16;

  localparam logic [7:0] BROADCAST_ADDR = 8'd0;
  localparam logic [7:0] SLAVE_ADDR_RST = 8'd1;

  // byte positions inside the request header
  localparam logic [8:0] POS_ADDR   = 9'd0;
  localparam logic [8:0] POS_FUNC   = 9'd1;
  localparam logic [8:0] POS_START1 = 9'd2;
  localparam logic [8:0] POS_START0 = 9'd3;
  localparam logic [8:0] POS_QTY1   = 9'd4;
  localparam logic [8:0] POS_QTY0   = 9'd5;
  localparam logic [8:0] POS_COUNT  = 9'd6;

  typedef enum logic [1:0] {
    ST_ACCEPTED     = 2'd0,
    ST_UNKNOWN_FUNC = 2'd1,
    ST_OTHER_ADDR   = 2'd2,
    ST_CRC_MISMATCH = 2'd3
  } status_t;

  typedef struct packed {
    status_t     status;
    logic        is_broadcast;
    logic [7:0]  func_code;
    logic [15:0] start_register;
    logic [15:0] quantity_or_value;
    logic [7:0]  byte_count;
    logic [8:0]  frame_length;
  } frame_res_t;

  // one byte of CRC-16, reflected polynomial, LSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== design/mbrtu_frame.sv =====
`timescale 1ns / 1ps

module mbrtu_frame (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_en,
  input  logic [7:0]             data_byte,
  input  logic                   idle_gap,
  input  logic [7:0]             slave_address,
  output logic                   frame_done,
  output mbrtu_pkg::frame_res_t  res
);

  logic [8:0]  bytes_r,   bytes_nxt;
  logic [8:0]  exp_len_r, exp_len_nxt;
  logic [7:0]  addr_r,    addr_nxt;
  logic [7:0]  func_r,    func_nxt;
  logic [15:0] start_r,   start_nxt;
  logic [15:0] qty_r,     qty_nxt;
  logic [7:0]  count_r,   count_nxt;
  logic [15:0] crc_r,     crc_nxt;
  logic [15:0] last_r,    last_nxt;

  logic [8:0]  upd_bytes, upd_exp;
  logic [7:0]  upd_addr, upd_func, upd_count;
  logic [15:0] upd_start, upd_qty, upd_crc, upd_last, rx_crc;
  logic        multi, known, ends;

  always_comb begin
    multi     = (func_r == mbrtu_pkg::FC_WRITE_COILS) || (func_r == mbrtu_pkg::FC_WRITE_REGS);
    upd_crc   = (bytes_r >= 9'd2) ? mbrtu_pkg::crc16_byte(crc_r, last_r[15:8]) : crc_r;
    upd_last  = {last_r[7:0], data_byte};
    upd_addr  = addr_r;
    upd_func  = func_r;
    upd_start = start_r;
    upd_qty   = qty_r;
    upd_count = count_r;
    upd_exp   = exp_len_r;
    case (bytes_r)
      mbrtu_pkg::POS_ADDR:   upd_addr = data_byte;
      mbrtu_pkg::POS_FUNC:   upd_func = data_byte;
      mbrtu_pkg::POS_START1: upd_start = {data_byte, start_r[7:0]};
      mbrtu_pkg::POS_START0: upd_start = {start_r[15:8], data_byte};
      mbrtu_pkg::POS_QTY1:   upd_qty = {data_byte, qty_r[7:0]};
      mbrtu_pkg::POS_QTY0:   upd_qty = {qty_r[15:8], data_byte};
      mbrtu_pkg::POS_COUNT: begin
        if (multi) begin
          upd_count = data_byte;
          upd_exp   = mbrtu_pkg::FRAME_LEN_MULTI + {1'b0, data_byte};
        end
      end
      default: ;
    endcase
    upd_bytes = bytes_r + 9'd1;
    ends      = !idle_gap && (upd_bytes >= upd_exp);
    frame_done = ends;

    known  = ((upd_func >= 8'd1) && (upd_func <= mbrtu_pkg::FC_LOW_MAX))
          || (upd_func == mbrtu_pkg::FC_WRITE_COILS) || (upd_func == mbrtu_pkg::FC_WRITE_REGS);
    rx_crc = {upd_last[7:0], upd_last[15:8]};
    if (!known) begin
      res.status = mbrtu_pkg::ST_UNKNOWN_FUNC;
    end else if (upd_addr != mbrtu_pkg::BROADCAST_ADDR && upd_addr != slave_address) begin
      res.status = mbrtu_pkg::ST_OTHER_ADDR;
    end else if (upd_crc != rx_crc) begin
      res.status = mbrtu_pkg::ST_CRC_MISMATCH;
    end else begin
      res.status = mbrtu_pkg::ST_ACCEPTED;
    end
    res.is_broadcast      = (upd_addr == mbrtu_pkg::BROADCAST_ADDR);
    res.func_code         = upd_func;
    res.start_register    = upd_start;
    res.quantity_or_value = upd_qty;
    res.byte_count        = upd_count;
    res.frame_length      = upd_exp;

    // idle gap or frame end: drop back to an empty frame
    if (idle_gap || ends) begin
      bytes_nxt   = 9'd0;
      exp_len_nxt = mbrtu_pkg::FRAME_LEN_BASE;
      addr_nxt    = 8'd0;
      func_nxt    = 8'd0;
      start_nxt   = 16'd0;
      qty_nxt     = 16'd0;
      count_nxt   = 8'd0;
      crc_nxt     = mbrtu_pkg::CRC_INIT;
      last_nxt    = 16'd0;
    end else begin
      bytes_nxt   = upd_bytes;
      exp_len_nxt = upd_exp;
      addr_nxt    = upd_addr;
      func_nxt    = upd_func;
      start_nxt   = upd_start;
      qty_nxt     = upd_qty;
      count_nxt   = upd_count;
      crc_nxt     = upd_crc;
      last_nxt    = upd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_r   <= 9'd0;
      exp_len_r <= mbrtu_pkg::FRAME_LEN_BASE;
      addr_r    <= 8'd0;
      func_r    <= 8'd0;
      start_r   <= 16'd0;
      qty_r     <= 16'd0;
      count_r   <= 8'd0;
      crc_r     <= mbrtu_pkg::CRC_INIT;
      last_r    <= 16'd0;
    end else if (step_en) begin
      bytes_r   <= bytes_nxt;
      exp_len_r <= exp_len_nxt;
      addr_r    <= addr_nxt;
      func_r    <= func_nxt;
      start_r   <= start_nxt;
      qty_r     <= qty_nxt;
      count_r   <= count_nxt;
      crc_r     <= crc_nxt;
      last_r    <= last_nxt;
    end
  end

endmodule

// ===== design/modbus_rtu_frame_receiver.sv =====
`timescale 1ns / 1ps

// Modbus RTU request receiver: takes one received byte (or an idle-gap marker that
// discards a partial frame) per request, one per clock cycle while no frame-ending byte
// waits. A byte goes into an input register and is then folded into the frame state and
// the CRC-16 at the edge that advances it out of that register; for a frame's last byte
// that same edge loads the result register and raises out_valid. Only a frame-ending byte
// waits on a pending result; the combinational CRC byte update sets the clock limit.
// One result per frame: status (accepted, unknown function, other address, CRC mismatch)
// plus the header fields. Write slave_address only while idle.
module modbus_rtu_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_idle_gap,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_is_broadcast,
  output logic [7:0]  out_func_code,
  output logic [15:0] out_start_register,
  output logic [15:0] out_quantity_or_value,
  output logic [7:0]  out_byte_count,
  output logic [8:0]  out_frame_length,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  logic                  s1_valid_r, s1_valid_nxt;
  logic [7:0]            s1_byte_r;
  logic                  s1_gap_r;
  logic [7:0]            slave_addr_r;
  logic                  out_valid_r, out_valid_nxt;
  mbrtu_pkg::frame_res_t out_res_r;
  mbrtu_pkg::frame_res_t res;
  logic                  frame_done;
  logic                  s1_adv;
  logic                  in_take;

  mbrtu_frame u_frame (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (s1_adv),
    .data_byte     (s1_byte_r),
    .idle_gap      (s1_gap_r),
    .slave_address (slave_addr_r),
    .frame_done    (frame_done),
    .res           (res)
  );

  // hold a frame-ending byte while the previous result waits
  assign s1_adv   = s1_valid_r && (!frame_done || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt  = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = (s1_adv && frame_done) ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      slave_addr_r <= mbrtu_pkg::SLAVE_ADDR_RST;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        slave_addr_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_data_byte;
      s1_gap_r  <= in_idle_gap;
    end
    if (s1_adv && frame_done) begin
      out_res_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_res_r.status;
  assign out_is_broadcast      = out_res_r.is_broadcast;
  assign out_func_code         = out_res_r.func_code;
  assign out_start_register    = out_res_r.start_register;
  assign out_quantity_or_value = out_res_r.quantity_or_value;
  assign out_byte_count        = out_res_r.byte_count;
  assign out_frame_length      = out_res_r.frame_length;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_res_r)))
    else $error("pending result overwritten");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.frame_length >= 9'd8 && out_res_r.frame_length <= 9'd264))
    else $error("frame length out of range");

  a_long_is_multi: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.frame_length != 9'd8) |->
      (out_res_r.func_code == mbrtu_pkg::FC_WRITE_COILS ||
       out_res_r.func_code == mbrtu_pkg::FC_WRITE_REGS))
    else $error("long frame without multi-write function");

  a_bcast_addr_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.is_broadcast) |-> (out_res_r.status != mbrtu_pkg::ST_OTHER_ADDR))
    else $error("broadcast frame flagged as other address");

endmodule
